// File: rtl/ffpc_pkg.sv
package ffpc_pkg;

  localparam int unsigned NameMax = 64;

  // phases of the frame parser
  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_NAME = 2'd1;
  localparam logic [1:0] KIND_RESP = 2'd2;

  // response reasons
  localparam logic [3:0] RSN_NONE       = 4'd0;
  localparam logic [3:0] RSN_SHORT      = 4'd1;
  localparam logic [3:0] RSN_BAD_SIZE   = 4'd2;
  localparam logic [3:0] RSN_NO_NAME    = 4'd3;
  localparam logic [3:0] RSN_NAME_LONG  = 4'd4;
  localparam logic [3:0] RSN_BAD_NAME   = 4'd5;
  localparam logic [3:0] RSN_NO_PUSH    = 4'd6;
  localparam logic [3:0] RSN_OVERFLOW   = 4'd7;
  localparam logic [3:0] RSN_INCOMPLETE = 4'd8;
  localparam logic [3:0] RSN_UNKNOWN    = 4'd9;
  localparam logic [3:0] RSN_TOO_LARGE  = 4'd10;
  localparam logic [3:0] RSN_TIMEOUT    = 4'd11;

  // events
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_OPENED  = 3'd1;
  localparam logic [2:0] EV_COMMIT  = 3'd2;
  localparam logic [2:0] EV_ABORTED = 3'd3;
  localparam logic [2:0] EV_RESTART = 3'd4;

  // register indexes
  localparam logic [2:0] REG_MAGIC   = 3'd0;
  localparam logic [2:0] REG_BEGIN   = 3'd1;
  localparam logic [2:0] REG_DATA    = 3'd2;
  localparam logic [2:0] REG_END     = 3'd3;
  localparam logic [2:0] REG_RESTART = 3'd4;
  localparam logic [2:0] REG_MAXSIZE = 3'd5;
  localparam logic [2:0] REG_HDR_TO  = 3'd6;
  localparam logic [2:0] REG_PAY_TO  = 3'd7;

  // one result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       acknowledged;
    logic [3:0] reason;
    logic [2:0] event_res;
    logic       last;
  } result_t;

  // up to two results from one input
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } pair_t;

  localparam int unsigned QDepth = 4;

endpackage

// File: rtl/framed_file_push_command_receiver.sv
// Framed file-push receiver: takes serial bytes and 1 ms ticks (one per cycle,
// s_axis_tready high whenever the result queue has room) and emits filename
// bytes, file data bytes and one ACK/NAK response per frame whose header
// completes. Each input's zero to two results enter a four-entry queue that
// holds the results of up to three inputs (one entry stays free); they are
// registered there and leave one per cycle while m_axis_tready is high on the
// master side. Configure only while idle.
module framed_file_push_command_receiver
  import ffpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // byte_value, acknowledged, reason, event_res
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);

  logic    fire, push, room;
  pair_t   pair;
  result_t res;

  assign s_axis_tready = room;
  assign fire = s_axis_tvalid && room;

  ffpc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_fire_i(fire), .in_tick_i(s_axis_tuser), .in_byte_i(s_axis_tdata),
    .push_o(push), .pair_o(pair)
  );

  ffpc_back u_back (
    .clk_i, .rst_ni, .push_i(push), .pair_i(pair), .can_take_o(room),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tdata = {res.event_res, res.reason, res.acknowledged, res.byte_value};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// File: rtl/ffpc_front.sv
module ffpc_front
  import ffpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_fire_i,
  input  logic        in_tick_i,
  input  logic [7:0]  in_byte_i,
  output logic        push_o,
  output pair_t       pair_o
);

  logic [31:0] magic_q;
  logic [7:0]  beg_q, dat_q, end_q, rst_code_q;
  logic [23:0] maxsz_q;
  logic [15:0] hto_q, pto_q;

  phase_e      ph_q, ph_d;
  logic [1:0]  mm_q, mm_d;
  logic [2:0]  hc_q, hc_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [31:0] len_q, len_d;
  logic [23:0] pc_q, pc_d;
  logic [15:0] to_q, to_d;
  logic        open_q, open_d;
  logic [23:0] exp_q, exp_d, rcv_q, rcv_d;
  logic [31:0] ann_q, ann_d;
  logic        inv_q, inv_d;

  logic        n_two, n_any;
  result_t     ra, rb;
  logic [24:0] sum_fit;
  logic        fits;
  logic [31:0] name_bytes;
  logic [23:0] pc_inc;
  logic [15:0] to_inc;
  logic [7:0]  want;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0; beg_q <= 8'd1; dat_q <= 8'd2; end_q <= 8'd3; rst_code_q <= 8'd4;
      maxsz_q <= 24'd2097152; hto_q <= 16'd5000; pto_q <= 16'd30000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAGIC:   magic_q <= cfg_data_i;
        REG_BEGIN:   beg_q <= cfg_data_i[7:0];
        REG_DATA:    dat_q <= cfg_data_i[7:0];
        REG_END:     end_q <= cfg_data_i[7:0];
        REG_RESTART: rst_code_q <= cfg_data_i[7:0];
        REG_MAXSIZE: maxsz_q <= cfg_data_i[23:0];
        REG_HDR_TO:  hto_q <= cfg_data_i[15:0];
        REG_PAY_TO:  pto_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // len never exceeds 24 bits once in payload or dispatch from payload
  assign sum_fit    = {1'b0, rcv_q} + {1'b0, len_q[23:0]};
  assign fits       = (len_q[31:24] == 8'd0) && (sum_fit <= {1'b0, exp_q});
  assign name_bytes = len_q - 32'd4;
  assign pc_inc     = pc_q + 24'd1;
  assign to_inc     = to_q + 16'd1;
  assign want       = magic_q[{mm_q, 3'b000} +: 8];

  function automatic result_t resp(logic ack, logic [3:0] r, logic [2:0] ev);
    result_t x;
    x.kind = KIND_RESP; x.byte_value = 8'd0; x.acknowledged = ack;
    x.reason = r; x.event_res = ev; x.last = 1'b0;
    return x;
  endfunction

  function automatic result_t bres(logic [1:0] k, logic [7:0] b);
    result_t x;
    x.kind = k; x.byte_value = b; x.acknowledged = 1'b0;
    x.reason = RSN_NONE; x.event_res = EV_NONE; x.last = 1'b0;
    return x;
  endfunction

  // parser and dispatch
  always_comb begin
    logic       do_disp, stream;
    logic [3:0] r;
    logic [2:0] ev;
    result_t    dr;
    ph_d = ph_q; mm_d = mm_q; hc_d = hc_q; cmd_d = cmd_q; len_d = len_q;
    pc_d = pc_q; to_d = to_q; open_d = open_q; exp_d = exp_q; rcv_d = rcv_q;
    ann_d = ann_q; inv_d = inv_q;
    n_any = 1'b0; n_two = 1'b0; ra = '0; rb = '0;
    do_disp = 1'b0; stream = 1'b0; r = RSN_NONE; ev = EV_NONE; dr = '0;
    if (in_tick_i) begin
      if (ph_q == PH_HEADER) begin
        to_d = to_inc;
        if (to_inc >= hto_q) begin
          ph_d = PH_SCAN; hc_d = 3'd0; to_d = 16'd0;
        end
      end else if (ph_q == PH_PAYLOAD) begin
        to_d = to_inc;
        if (to_inc >= pto_q) begin
          ph_d = PH_SCAN; to_d = 16'd0; n_any = 1'b1;
          ra = resp(1'b0, RSN_TIMEOUT, EV_NONE);
        end
      end
    end else if (ph_q == PH_HEADER) begin
      case (hc_q)
        3'd0: cmd_d = in_byte_i;
        3'd1: len_d[7:0] = in_byte_i;
        3'd2: len_d[15:8] = in_byte_i;
        3'd3: len_d[23:16] = in_byte_i;
        default: len_d[31:24] = in_byte_i;
      endcase
      hc_d = hc_q + 3'd1;
      if (hc_q == 3'd4) begin
        hc_d = 3'd0; pc_d = '0; to_d = '0; ann_d = '0; inv_d = 1'b0;
        if (len_d == 32'd0) begin
          ph_d = PH_SCAN; do_disp = 1'b1;
        end else if (len_d > {8'd0, maxsz_q}) begin
          ph_d = PH_SCAN; n_any = 1'b1;
          ra = resp(1'b0, RSN_TOO_LARGE, EV_NONE);
        end else begin
          ph_d = PH_PAYLOAD;
        end
      end
    end else if (ph_q == PH_PAYLOAD) begin
      if (cmd_q == beg_q) begin
        if (pc_q < 24'd4) begin
          ann_d[{pc_q[1:0], 3'b000} +: 8] = in_byte_i;
        end else begin
          if (in_byte_i == 8'h2f || in_byte_i == 8'h5c || in_byte_i == 8'h00)
            inv_d = 1'b1;
          if (pc_q - 24'd4 < 24'(NameMax)) begin
            stream = 1'b1; ra = bres(KIND_NAME, in_byte_i);
          end
        end
      end else if (cmd_q == dat_q) begin
        if (open_q && fits) begin
          stream = 1'b1; ra = bres(KIND_DATA, in_byte_i);
        end
      end
      pc_d = pc_inc;
      n_any = stream;
      if ({8'd0, pc_inc} == len_q) begin
        ph_d = PH_SCAN; do_disp = 1'b1;
      end
    end else begin
      ph_d = PH_SCAN;
      if (in_byte_i != want) begin
        mm_d = (in_byte_i == magic_q[7:0]) ? 2'd1 : 2'd0;
      end else if (mm_q == 2'd3) begin
        mm_d = 2'd0; ph_d = PH_HEADER; hc_d = 3'd0; cmd_d = 8'd0;
        len_d = '0; to_d = '0;
      end else begin
        mm_d = mm_q + 2'd1;
      end
    end

    // dispatch uses header values (len_d/cmd_d) and payload-updated ann/inv
    if (do_disp) begin
      if (cmd_d == beg_q) begin
        ev = open_q ? EV_ABORTED : EV_NONE;
        open_d = 1'b0; exp_d = '0; rcv_d = '0;
        if (len_d < 32'd4) r = RSN_SHORT;
        else if (ann_d == 32'd0 || ann_d > {8'd0, maxsz_q}) r = RSN_BAD_SIZE;
        else if (len_d == 32'd4) r = RSN_NO_NAME;
        else if (name_bytes > 32'(NameMax)) r = RSN_NAME_LONG;
        else if (inv_d) r = RSN_BAD_NAME;
        if (r != RSN_NONE) dr = resp(1'b0, r, ev);
        else begin
          open_d = 1'b1; exp_d = ann_d[23:0]; dr = resp(1'b1, RSN_NONE, EV_OPENED);
        end
      end else if (cmd_d == dat_q) begin
        if (!open_q) dr = resp(1'b0, RSN_NO_PUSH, EV_NONE);
        else if (!fits) begin
          open_d = 1'b0; exp_d = '0; rcv_d = '0;
          dr = resp(1'b0, RSN_OVERFLOW, EV_ABORTED);
        end else begin
          rcv_d = sum_fit[23:0]; dr = resp(1'b1, RSN_NONE, EV_NONE);
        end
      end else if (cmd_d == end_q) begin
        if (!open_q) dr = resp(1'b0, RSN_NO_PUSH, EV_NONE);
        else begin
          open_d = 1'b0; exp_d = '0; rcv_d = '0;
          if (rcv_q != exp_q) dr = resp(1'b0, RSN_INCOMPLETE, EV_ABORTED);
          else dr = resp(1'b1, RSN_NONE, EV_COMMIT);
        end
      end else if (cmd_d == rst_code_q) begin
        dr = resp(1'b1, RSN_NONE, EV_RESTART);
      end else begin
        dr = resp(1'b0, RSN_UNKNOWN, EV_NONE);
      end
      if (stream) begin
        n_two = 1'b1; rb = dr;
      end else begin
        ra = dr;
      end
      n_any = 1'b1;
    end
  end

  // fits uses len_q; on a zero-length header dispatch len_d is 0 and len_q
  // may differ, but data dispatch only needs len for sum: zero length adds 0
  // only if len_q matches. Header dispatch happens with len_d==0, so
  // len_q[31:24]=0 from magic clear and len_q[23:0] low bytes were written;
  // all bytes equal zero then, so len_q==0 too.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_SCAN; mm_q <= '0; hc_q <= '0; cmd_q <= '0; len_q <= '0;
      pc_q <= '0; to_q <= '0; open_q <= 1'b0; exp_q <= '0; rcv_q <= '0;
      ann_q <= '0; inv_q <= 1'b0;
    end else if (in_fire_i) begin
      ph_q <= ph_d; mm_q <= mm_d; hc_q <= hc_d; cmd_q <= cmd_d; len_q <= len_d;
      pc_q <= pc_d; to_q <= to_d; open_q <= open_d; exp_q <= exp_d; rcv_q <= rcv_d;
      ann_q <= ann_d; inv_q <= inv_d;
    end
  end

  always_comb begin
    pair_o = '0;
    pair_o.two = n_two;
    pair_o.r0 = ra;
    pair_o.r1 = rb;
    pair_o.r0.last = !n_two;
    pair_o.r1.last = 1'b1;
  end
  assign push_o = in_fire_i && n_any;

`ifndef SYNTHESIS
  ap_open_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (exp_q == '0 && rcv_q == '0)) else $error("closed transfer has sizes");
  ap_rcv_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> rcv_q <= exp_q) else $error("received exceeds expected");
  ap_hc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= 3'd4) else $error("header count out of range");
`endif

endmodule

// File: rtl/ffpc_back.sv
module ffpc_back
  import ffpc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  pair_t   pair_i,
  output logic    can_take_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam int unsigned AW = $clog2(QDepth);

  pair_t         mem_q [QDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          sub_q;
  logic          pop_item;
  logic          deq;

  assign out_valid_o = cnt_q != '0;
  assign out_o = sub_q ? mem_q[rp_q].r1 : mem_q[rp_q].r0;
  assign deq = out_valid_o && out_ready_i;
  assign pop_item = deq && (sub_q || !mem_q[rp_q].two);
  // keep one free slot; with three items held, a new item is taken only if one leaves in the same cycle
  assign can_take_o = (cnt_q < (AW+1)'(QDepth - 1)) ||
                      ((cnt_q == (AW+1)'(QDepth - 1)) && pop_item);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; sub_q <= 1'b0;
    end else begin
      if (push_i) wp_q <= wp_q + AW'(1);
      if (deq) sub_q <= !pop_item;
      if (pop_item) rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_item);
    end
  end

`ifndef SYNTHESIS
  ap_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(QDepth)) else $error("queue overflow");
  ap_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> out_valid_o) else $error("second half without entry");
  ap_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < (AW+1)'(QDepth) || pop_item)) else $error("push into full queue");
`endif

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import ffpc_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam int unsigned CycleLimit = 2000000;

  // one expected or observed result
  typedef struct {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       acknowledged;
    logic [3:0] reason;
    logic [2:0] event_res;
    logic       last;
  } rec_t;

  // predictor of the receiver plus queue of pending results
  class push_scoreboard;
    logic [31:0] magic;
    logic [7:0]  c_begin, c_data, c_end, c_restart;
    logic [23:0] max_size;
    logic [15:0] hdr_to, pay_to;

    logic [1:0]  match_cnt;
    phase_e      ph;
    logic [2:0]  hdr_cnt;
    logic [7:0]  cmd;
    logic [31:0] flen;
    logic [23:0] pay_cnt;
    logic [15:0] tick_cnt;
    logic        xfer_open;
    logic [23:0] exp_size, rcv_size;
    logic [31:0] ann_size;
    logic        bad_name;

    rec_t pending[$];
    rec_t step_out[$];
    int   errors;

    function new();
      magic = 0; c_begin = 1; c_data = 2; c_end = 3; c_restart = 4;
      max_size = 24'd2097152; hdr_to = 5000; pay_to = 30000;
      match_cnt = 0; ph = PH_SCAN; hdr_cnt = 0; cmd = 0; flen = 0; pay_cnt = 0;
      tick_cnt = 0; xfer_open = 0; exp_size = 0; rcv_size = 0; ann_size = 0;
      bad_name = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_MAGIC:   magic = v;
        REG_BEGIN:   c_begin = v[7:0];
        REG_DATA:    c_data = v[7:0];
        REG_END:     c_end = v[7:0];
        REG_RESTART: c_restart = v[7:0];
        REG_MAXSIZE: max_size = v[23:0];
        REG_HDR_TO:  hdr_to = v[15:0];
        default:     pay_to = v[15:0];
      endcase
    endfunction

    function void push(logic [1:0] k, logic [7:0] b, logic a, logic [3:0] r,
                       logic [2:0] e);
      rec_t x;
      x.kind = k; x.byte_value = b; x.acknowledged = a; x.reason = r;
      x.event_res = e; x.last = 0;
      step_out.push_back(x);
    endfunction

    function bit chunk_fits();
      return ({32'd0, 8'd0, rcv_size} + {32'd0, flen}) <= {40'd0, exp_size};
    endfunction

    function void close_xfer();
      xfer_open = 0; exp_size = 0; rcv_size = 0;
    endfunction

    // act on a complete frame
    function void act_on_frame();
      logic [2:0]  ev;
      logic [3:0]  r;
      logic [31:0] nlen;
      if (cmd == c_begin) begin
        ev = xfer_open ? EV_ABORTED : EV_NONE;
        nlen = (flen >= 4) ? flen - 4 : 0;
        r = RSN_NONE;
        close_xfer();
        if (flen < 4) r = RSN_SHORT;
        else if (ann_size == 0 || ann_size > {8'd0, max_size}) r = RSN_BAD_SIZE;
        else if (nlen == 0) r = RSN_NO_NAME;
        else if (nlen > NameMax) r = RSN_NAME_LONG;
        else if (bad_name) r = RSN_BAD_NAME;
        if (r != RSN_NONE) push(KIND_RESP, 0, 0, r, ev);
        else begin
          xfer_open = 1; exp_size = ann_size[23:0]; rcv_size = 0;
          push(KIND_RESP, 0, 1, RSN_NONE, EV_OPENED);
        end
      end else if (cmd == c_data) begin
        if (!xfer_open) push(KIND_RESP, 0, 0, RSN_NO_PUSH, EV_NONE);
        else if (!chunk_fits()) begin
          close_xfer();
          push(KIND_RESP, 0, 0, RSN_OVERFLOW, EV_ABORTED);
        end else begin
          rcv_size = rcv_size + flen[23:0];
          push(KIND_RESP, 0, 1, RSN_NONE, EV_NONE);
        end
      end else if (cmd == c_end) begin
        if (!xfer_open) push(KIND_RESP, 0, 0, RSN_NO_PUSH, EV_NONE);
        else if (rcv_size != exp_size) begin
          close_xfer();
          push(KIND_RESP, 0, 0, RSN_INCOMPLETE, EV_ABORTED);
        end else begin
          close_xfer();
          push(KIND_RESP, 0, 1, RSN_NONE, EV_COMMIT);
        end
      end else if (cmd == c_restart) push(KIND_RESP, 0, 1, RSN_NONE, EV_RESTART);
      else push(KIND_RESP, 0, 0, RSN_UNKNOWN, EV_NONE);
    endfunction

    function void note_input(logic op, logic [7:0] b);
      logic [7:0]  want;
      logic [31:0] i;
      step_out.delete();
      if (op == OP_TICK) begin
        if (ph == PH_HEADER) begin
          tick_cnt++;
          if (tick_cnt >= hdr_to) begin
            ph = PH_SCAN; hdr_cnt = 0; tick_cnt = 0;
          end
        end else if (ph == PH_PAYLOAD) begin
          tick_cnt++;
          if (tick_cnt >= pay_to) begin
            ph = PH_SCAN; tick_cnt = 0;
            push(KIND_RESP, 0, 0, RSN_TIMEOUT, EV_NONE);
          end
        end else ph = PH_SCAN;
      end else if (ph == PH_HEADER) begin
        if (hdr_cnt == 0) cmd = b;
        else flen = flen | ({24'd0, b} << (8 * (hdr_cnt - 1)));
        hdr_cnt++;
        if (hdr_cnt == 5) begin
          hdr_cnt = 0; pay_cnt = 0; tick_cnt = 0; ann_size = 0; bad_name = 0;
          if (flen == 0) begin
            ph = PH_SCAN; act_on_frame();
          end else if (flen > {8'd0, max_size}) begin
            ph = PH_SCAN; push(KIND_RESP, 0, 0, RSN_TOO_LARGE, EV_NONE);
          end else ph = PH_PAYLOAD;
        end
      end else if (ph == PH_PAYLOAD) begin
        i = {8'd0, pay_cnt};
        if (cmd == c_begin) begin
          if (i < 4) ann_size = ann_size | ({24'd0, b} << (8 * i));
          else begin
            if (b == "/" || b == "\\" || b == 0) bad_name = 1;
            if (i - 4 < NameMax) push(KIND_NAME, b, 0, 0, 0);
          end
        end else if (cmd == c_data) begin
          if (xfer_open && chunk_fits()) push(KIND_DATA, b, 0, 0, 0);
        end
        pay_cnt = pay_cnt + 1;
        if ({8'd0, pay_cnt} == flen) begin
          ph = PH_SCAN; act_on_frame();
        end
      end else begin
        ph = PH_SCAN;
        want = 8'(magic >> (8 * match_cnt));
        if (b != want) match_cnt = (b == magic[7:0]) ? 2'd1 : 2'd0;
        else if (match_cnt == 3) begin
          match_cnt = 0; ph = PH_HEADER; hdr_cnt = 0; cmd = 0; flen = 0;
          tick_cnt = 0;
        end else match_cnt = match_cnt + 1;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
      foreach (step_out[k]) pending.push_back(step_out[k]);
    endfunction

    function void check_result(rec_t got);
      rec_t w;
      if (pending.size() == 0) begin
        $error("unexpected result kind %0d byte %0h", got.kind, got.byte_value);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.kind != w.kind) begin
        $error("kind exp %0d got %0d", w.kind, got.kind); errors++;
      end
      if (got.byte_value != w.byte_value) begin
        $error("byte_value exp %0h got %0h", w.byte_value, got.byte_value); errors++;
      end
      if (got.acknowledged != w.acknowledged) begin
        $error("acknowledged exp %0d got %0d", w.acknowledged, got.acknowledged);
        errors++;
      end
      if (got.reason != w.reason) begin
        $error("reason exp %0d got %0d", w.reason, got.reason); errors++;
      end
      if (got.event_res != w.event_res) begin
        $error("event_res exp %0d got %0d", w.event_res, got.event_res); errors++;
      end
      if (got.last != w.last) begin
        $error("last exp %0d got %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = 0;
  logic [31:0] cfg_data_i = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;   // data_byte
  logic        s_axis_tuser = 0;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;       // byte_value, acknowledged, reason, event_res
  logic [1:0]  m_axis_tuser;       // kind
  logic        m_axis_tlast;

  framed_file_push_command_receiver dut (.*);

  push_scoreboard sb = new();
  int unsigned sender_idle = 0;    // percent
  int unsigned recv_stall = 0;     // percent
  int unsigned phase_no = 0;       // current random phase
  logic        hold_on = 0;        // forced receiver stall in progress
  int unsigned cycles = 0;
  int unsigned sent = 0;

  // current configuration as driven into the block
  logic [31:0] cur_magic;
  logic [7:0]  cur_begin, cur_data, cur_end, cur_restart;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // long receiver stall in the no-idle phase while the sender keeps going
  initial begin
    wait (phase_no == 4);
    hold_on = 1;
    repeat (300) @(posedge clk_i);
    hold_on = 0;
  end

  // receiver: ready pattern and result check
  always @(posedge clk_i) begin
    rec_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.byte_value = m_axis_tdata[7:0];
        got.acknowledged = m_axis_tdata[8];
        got.reason = m_axis_tdata[12:9];
        got.event_res = m_axis_tdata[15:13];
        got.last = m_axis_tlast;
        sb.check_result(got);
      end
      if (hold_on) m_axis_tready <= 0;
      else m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    sb.write_reg(idx, v);
    case (idx)
      REG_MAGIC:   cur_magic = v;
      REG_BEGIN:   cur_begin = v[7:0];
      REG_DATA:    cur_data = v[7:0];
      REG_END:     cur_end = v[7:0];
      REG_RESTART: cur_restart = v[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // offer one transaction, hold until accepted; valid stays up for the next
  task automatic send(logic op, logic [7:0] b);
    while ($urandom_range(99) < sender_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tuser <= op; s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, b);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send(OP_BYTE, b);
  endtask

  task automatic send_magic();
    for (int k = 0; k < 4; k++) send_byte(cur_magic[8*k +: 8]);
  endtask

  task automatic send_header(logic [7:0] c, logic [31:0] len);
    send_magic();
    send_byte(c);
    for (int k = 0; k < 4; k++) send_byte(len[8*k +: 8]);
  endtask

  // begin frame: size then name
  task automatic send_begin(logic [31:0] fsize, int nlen, bit bad);
    logic [7:0] ch;
    send_header(cur_begin, 4 + nlen);
    for (int k = 0; k < 4; k++) send_byte(fsize[8*k +: 8]);
    for (int k = 0; k < nlen; k++) begin
      ch = 8'($urandom_range(33, 126));
      if (ch == "/" || ch == "\\") ch = "a";
      if (bad && k == nlen / 2) ch = ($urandom_range(2) == 0) ? "/" :
                                      ($urandom_range(1) ? "\\" : 8'h00);
      send_byte(ch);
    end
  endtask

  task automatic send_data(int len);
    send_header(cur_data, len);
    for (int k = 0; k < len; k++) send_byte(8'($urandom));
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // one random item of the mix of frames, partial magics, stray bytes and ticks
  task automatic random_frame();
    int sel;
    int sz;
    sel = $urandom_range(99);
    if (sel < 25) begin
      sz = $urandom_range(1, 12);
      send_begin(sz, $urandom_range(1, 6), $urandom_range(15) == 0);
    end else if (sel < 55) send_data($urandom_range(0, 6));
    else if (sel < 65) send_header(cur_end, $urandom_range(0, 2));
    else if (sel < 70) send_header(cur_restart, 0);
    else if (sel < 75) send_header(8'($urandom), $urandom_range(0, 3));
    else if (sel < 80) begin
      send_magic();
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
    end else if (sel < 90) send(OP_TICK, 8'($urandom));
    else send_byte(8'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    cur_magic = 0; cur_begin = 1; cur_data = 2; cur_end = 3; cur_restart = 4;

    // directed: default codes, zero magic
    send_header(cur_end, 0);
    send_begin(5, 3, 0);
    send_data(3);
    send_data(2);
    send_header(cur_end, 0);
    send_data(1);
    send_header(cur_restart, 0);
    send_header(8'hFF, 0);
    send_header(cur_begin, 2);
    repeat (2) send_byte(8'h00);
    wait_drain();

    // magic with fallback, tiny timeouts, small max size
    write_reg(REG_MAGIC, 32'hA5_5A_C3_3C);
    write_reg(REG_HDR_TO, 16'd2);
    write_reg(REG_PAY_TO, 16'd1);
    write_reg(REG_MAXSIZE, 24'd8);
    send_byte(8'h3C); send_byte(8'h3C); send_byte(8'hC3); send_byte(8'h5A);
    send_byte(8'hA5);
    send(OP_TICK, 0); send(OP_TICK, 8'hFF);
    send_header(cur_begin, 32'hFFFF_FFFF);
    send_header(cur_begin, 9);
    send_byte(8'h01);
    send(OP_TICK, 0);
    send_begin(9, 0, 0);
    send_begin(4, 65, 0);
    send_begin(4, 2, 1);
    wait_drain();
    write_reg(REG_MAXSIZE, 24'hFFFFFF);
    send_begin(32'h00FF_FFFF, 70, 0);
    send_begin(3, 64, 0);
    send_data(4);
    send_header(cur_end, 1);
    send_byte(8'h11);
    wait_drain();

    // random phases with differing configurations
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin sender_idle = 0; recv_stall = 0; end
        1: begin sender_idle = 88; recv_stall = 0; end
        2: begin sender_idle = 0; recv_stall = 88; end
        default: begin sender_idle = 15; recv_stall = 15; end
      endcase
      write_reg(REG_MAGIC, (p == 5) ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_BEGIN, (p == 6) ? 8'hFF : $urandom_range(0, 255));
      write_reg(REG_DATA, (p == 7) ? cur_begin : $urandom_range(0, 255));
      write_reg(REG_END, (p == 6) ? cur_data : $urandom_range(0, 255));
      write_reg(REG_RESTART, (p == 4) ? 8'h00 : $urandom_range(0, 255));
      write_reg(REG_MAXSIZE, (p == 3) ? 24'd1 : $urandom_range(4, 40));
      write_reg(REG_HDR_TO, (p == 2) ? 16'hFFFF : $urandom_range(1, 6));
      write_reg(REG_PAY_TO, (p == 2) ? 16'hFFFF : $urandom_range(1, 30));
      phase_no = p;
      while (sent < 100 + (p + 1) * 230) random_frame();
      wait_drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: sim.f
rtl/ffpc_pkg.sv
rtl/ffpc_front.sv
rtl/ffpc_back.sv
rtl/framed_file_push_command_receiver.sv
tb/sv/testbench.sv
